// ===== design/vector_angle_defines.svh =====
// ----------------------------------------------------------------------------
// vector_angle_defines
// assertion macros for the vector angle block
// ----------------------------------------------------------------------------
`ifndef VECTOR_ANGLE_DEFINES_SVH
`define VECTOR_ANGLE_DEFINES_SVH

// implication checked on every edge outside reset
`define VA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vector_angle check failed");

// next-cycle implication checked outside reset
`define VA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vector_angle check failed");

`endif

// ===== design/va_pkg.sv =====
// ----------------------------------------------------------------------------
// va_pkg
// shared types and constants of the vector angle block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package va_pkg;

  localparam int MAX_LEN_DEF  = 1024;
  localparam int ACC_W        = 48;
  localparam int ELEM_W       = 16;
  localparam int NORM_W       = 24;
  localparam int ANGLE_W      = 15;
  localparam int Q_DEPTH      = 2;
  localparam int CORDIC_STEPS = 17;
  localparam int ZW           = 20;
  localparam logic [ZW-1:0] PI_Q16 = ZW'(205887);
  localparam logic [ANGLE_W-1:0] PI_Q13 = ANGLE_W'(25736);
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // finished sums handed from front to back
  typedef struct packed {
    logic signed [ACC_W-1:0] dot;
    logic [ACC_W-1:0]        sum_a;
    logic [ACC_W-1:0]        sum_b;
  } sums_t;

  // arctangent table in Q.16 radians
  function automatic logic [ZW-1:0] atan_q16(input logic [4:0] i);
    logic [ZW-1:0] v;
    unique case (i)
      5'd0:  v = ZW'(51472);
      5'd1:  v = ZW'(30386);
      5'd2:  v = ZW'(16055);
      5'd3:  v = ZW'(8150);
      5'd4:  v = ZW'(4091);
      5'd5:  v = ZW'(2047);
      5'd6:  v = ZW'(1024);
      5'd7:  v = ZW'(512);
      5'd8:  v = ZW'(256);
      5'd9:  v = ZW'(128);
      5'd10: v = ZW'(64);
      5'd11: v = ZW'(32);
      5'd12: v = ZW'(16);
      5'd13: v = ZW'(8);
      5'd14: v = ZW'(4);
      5'd15: v = ZW'(2);
      5'd16: v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== design/va_if.sv =====
// ----------------------------------------------------------------------------
// va_in_if / va_out_if
// stream channels of the vector angle block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface va_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] elem_a;
  logic signed [15:0] elem_b;
  logic               last;
  modport source (output valid, elem_a, elem_b, last, input ready);
  modport sink (input valid, elem_a, elem_b, last, output ready);
endinterface

interface va_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] dot_product;
  logic [23:0]        norm_a;
  logic [23:0]        norm_b;
  logic [14:0]        angle;
  logic               angle_valid;
  modport source (output valid, dot_product, norm_a, norm_b, angle, angle_valid,
                  input ready);
  modport sink (input valid, dot_product, norm_a, norm_b, angle, angle_valid,
                output ready);
endinterface
`default_nettype wire

// ===== design/va_front.sv =====
// ----------------------------------------------------------------------------
// va_front
// two-stage multiply-accumulate of element pairs with saturation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module va_front import va_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  va_in_if.sink     in_ch,
  output logic      push,
  output sums_t     push_data,
  input  wire logic q_full
);

  logic signed [31:0] pab, paa, pbb;
  logic               p_vld, p_last;
  logic signed [ACC_W-1:0] dot;
  logic [ACC_W-1:0] sa, sb;
  logic signed [ACC_W:0] dot_s;
  logic [ACC_W:0] sa_s, sb_s;
  logic signed [ACC_W-1:0] dot_n;
  logic [ACC_W-1:0] sa_n, sb_n;
  logic stall;

  // a last pair in stage two waits for room in the queue
  assign stall = p_vld && p_last && q_full;
  assign in_ch.ready = !stall;

  // product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else if (!stall) begin
      p_vld <= in_ch.valid;
    end
    if (!stall) begin
      pab    <= in_ch.elem_a * in_ch.elem_b;
      paa    <= in_ch.elem_a * in_ch.elem_a;
      pbb    <= in_ch.elem_b * in_ch.elem_b;
      p_last <= in_ch.last;
    end
  end

  // saturating sums
  always_comb begin
    dot_s = {dot[ACC_W-1], dot} + (ACC_W+1)'(pab);
    sa_s  = {1'b0, sa} + (ACC_W+1)'($unsigned(paa));
    sb_s  = {1'b0, sb} + (ACC_W+1)'($unsigned(pbb));
    if (dot_s[ACC_W] != dot_s[ACC_W-1]) dot_n = dot_s[ACC_W] ? ACC_MIN : ACC_MAX;
    else dot_n = dot_s[ACC_W-1:0];
    sa_n = (sa_s > (ACC_W+1)'(ACC_MAX)) ? ACC_MAX : sa_s[ACC_W-1:0];
    sb_n = (sb_s > (ACC_W+1)'(ACC_MAX)) ? ACC_MAX : sb_s[ACC_W-1:0];
  end

  assign push = p_vld && p_last && !q_full;
  assign push_data = '{dot: dot_n, sum_a: sa_n, sum_b: sb_n};

  // accumulators clear after a vector is handed on
  always_ff @(posedge clk) begin
    if (rst) begin
      dot <= '0;
      sa  <= '0;
      sb  <= '0;
    end else if (p_vld && !stall) begin
      if (p_last) begin
        dot <= '0;
        sa  <= '0;
        sb  <= '0;
      end else begin
        dot <= dot_n;
        sa  <= sa_n;
        sb  <= sb_n;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/va_queue.sv =====
// ----------------------------------------------------------------------------
// va_queue
// short queue of finished sums between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module va_queue import va_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  sums_t     push_data,
  output logic      full,
  output logic      not_empty,
  input  wire logic pop,
  output sums_t     pop_data
);

  sums_t mem [Q_DEPTH];
  logic wp, rp;
  logic [1:0] cnt;

  assign full = cnt == 2'(Q_DEPTH);
  assign not_empty = cnt != 2'd0;
  assign pop_data = mem[rp];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
    if (push) mem[wp] <= push_data;
  end

endmodule
`default_nettype wire

// ===== design/va_back.sv =====
// ----------------------------------------------------------------------------
// va_back
// sequencer for square roots, cosine division, sine root and cordic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module va_back import va_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_vld,
  input  sums_t     q_data,
  output logic      pop,
  va_out_if.source  out_ch
);

  localparam logic [3:0] S_IDLE = 4'd0, S_SQA = 4'd1, S_SQB = 4'd2, S_MUL = 4'd3,
                         S_DIV = 4'd4, S_CC = 4'd5, S_SQS = 4'd6, S_COR = 4'd7,
                         S_FIN = 4'd8, S_OUT = 4'd9;

  logic [3:0] state;
  logic [5:0] cnt;
  logic signed [ACC_W-1:0] dot;
  logic [ACC_W-1:0] mag, den;
  logic [NORM_W-1:0] na, nb;
  logic [2*NORM_W-1:0] nn;
  // shared square root unit (one result bit per step)
  logic [63:0] sq_v, sq_r, sq_b;
  logic [63:0] sq_t;
  logic [30:0] q, c;
  logic [ACC_W:0] rem;
  logic [ACC_W:0] rem2;
  logic signed [33:0] x, y;
  logic signed [ZW:0] z;
  logic signed [ZW+1:0] a_f;
  logic signed [ZW+1:0] a_r;
  logic [61:0] cc;
  logic [4:0] ci;

  assign pop = state == S_IDLE && q_vld && !out_ch.valid;
  assign sq_t = sq_r + sq_b;
  assign rem2 = {rem[ACC_W-1:0], 1'b0};
  // full-width product of the two norms
  assign nn = na * nb;
  assign a_f = dot[ACC_W-1] ? (ZW+2)'($signed({1'b0, PI_Q16})) - (ZW+2)'(z)
                            : (ZW+2)'(z);
  assign a_r = (a_f + (ZW+2)'(4)) >>> 3;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      unique case (state)
        S_IDLE: if (pop) begin
          dot   <= q_data.dot;
          mag   <= q_data.dot[ACC_W-1] ? ACC_W'(-q_data.dot) : q_data.dot;
          den   <= q_data.sum_b;
          sq_v  <= 64'(q_data.sum_a);
          sq_r  <= '0;
          sq_b  <= 64'd1 << 62;
          cnt   <= '0;
          state <= S_SQA;
        end
        S_SQA, S_SQB, S_SQS: begin
          // one bit pair of the radicand per cycle
          if (sq_v >= sq_t) begin
            sq_v <= sq_v - sq_t;
            sq_r <= (sq_r >> 1) + sq_b;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_b <= sq_b >> 2;
          if (sq_b == 64'd1) begin
            if (state == S_SQA) begin
              na    <= NORM_W'((sq_v >= sq_t) ? (sq_r >> 1) + sq_b : sq_r >> 1);
              sq_v  <= 64'(den);
              sq_r  <= '0;
              sq_b  <= 64'd1 << 62;
              state <= S_SQB;
            end else if (state == S_SQB) begin
              nb    <= NORM_W'((sq_v >= sq_t) ? (sq_r >> 1) + sq_b : sq_r >> 1);
              state <= S_MUL;
            end else begin
              y  <= 34'((sq_v >= sq_t) ? (sq_r >> 1) + sq_b : sq_r >> 1);
              x  <= 34'(c);
              z  <= '0;
              ci <= '0;
              state <= S_COR;
            end
          end
        end
        S_MUL: begin
          den   <= nn;
          q     <= '0;
          cnt   <= '0;
          state <= (na == '0 || nb == '0) ? S_OUT : S_DIV;
          rem   <= '0;
        end
        S_DIV: begin
          // restoring division, one quotient bit per cycle
          if (cnt == 6'd0) begin
            if (mag >= den) begin
              c     <= 31'd1 << 30;
              state <= S_CC;
            end else begin
              rem <= {1'b0, mag};
              cnt <= 6'd1;
            end
          end else begin
            if (rem2 >= {1'b0, den}) begin
              rem <= rem2 - {1'b0, den};
              q   <= {q[29:0], 1'b1};
            end else begin
              rem <= rem2;
              q   <= {q[29:0], 1'b0};
            end
            cnt <= cnt + 6'd1;
            if (cnt == 6'd30) begin
              c     <= (rem2 >= {1'b0, den}) ? {q[29:0], 1'b1} : {q[29:0], 1'b0};
              state <= S_CC;
            end
          end
        end
        S_CC: begin
          cc    <= 62'(c) * 62'(c);
          state <= S_FIN;
        end
        S_FIN: begin
          if (cnt != 6'd63) begin
            sq_v  <= (64'd1 << 60) - 64'(cc);
            sq_r  <= '0;
            sq_b  <= 64'd1 << 62;
            cnt   <= 6'd63;
            state <= S_SQS;
          end else begin
            // clamp and round the angle
            if (a_r < 0) out_ch.angle <= '0;
            else if (a_r > (ZW+2)'(PI_Q13)) out_ch.angle <= PI_Q13;
            else out_ch.angle <= ANGLE_W'(a_r);
            out_ch.angle_valid <= 1'b1;
            out_ch.dot_product <= dot;
            out_ch.norm_a <= na;
            out_ch.norm_b <= nb;
            out_ch.valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_COR: begin
          // one vectoring rotation per cycle
          if (y >= 0) begin
            x <= x + (y >>> ci);
            y <= y - (x >>> ci);
            z <= z + (ZW+1)'(atan_q16(ci));
          end else begin
            x <= x - (y >>> ci);
            y <= y + (x >>> ci);
            z <= z - (ZW+1)'(atan_q16(ci));
          end
          ci <= ci + 5'd1;
          if (ci == 5'(CORDIC_STEPS - 1)) state <= S_FIN;
        end
        S_OUT: begin
          out_ch.angle <= '0;
          out_ch.angle_valid <= 1'b0;
          out_ch.dot_product <= dot;
          out_ch.norm_a <= na;
          out_ch.norm_b <= nb;
          out_ch.valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/vector_angle.sv =====
// ----------------------------------------------------------------------------
// vector_angle
// angle between two vectors streamed as Q8.8 element pairs
// ----------------------------------------------------------------------------
// channel  dir  payload
// in_ch    in   elem_a, elem_b, last
// out_ch   out  dot_product, norm_a, norm_b, angle, angle_valid
//
// element pairs are taken one per cycle unless a last pair stalls; the
// multiply-add pipe is two deep; the back sequencer runs from queue pop to
// result valid through three 32-step square roots, a restoring divide, 17 cordic
// rotations and control states; a cosine of one skips the divide
// a two-entry queue lets the front keep streaming; only a last pair stalls, on full
// rst is synchronous and clears the accumulators and all control state
`timescale 1ns / 1ps
`default_nettype none
`include "vector_angle_defines.svh"
module vector_angle import va_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  va_in_if.sink     in_ch,
  va_out_if.source  out_ch
);

  logic  push, pop, q_full, q_vld;
  sums_t push_data, pop_data;

  va_front u_front (.clk, .rst, .in_ch, .push, .push_data, .q_full);
  va_queue u_queue (.clk, .rst, .push, .push_data, .full(q_full), .not_empty(q_vld),
                    .pop, .pop_data);
  va_back u_back (.clk, .rst, .q_vld, .q_data(pop_data), .pop, .out_ch);

  `VA_ASSERT_IMP(a_no_push_full, push, !q_full)
  `VA_ASSERT_IMP(a_pop_nonempty, pop, q_vld)
  `VA_ASSERT_IMP(a_zero_angle, out_ch.valid && !out_ch.angle_valid, out_ch.angle == '0)

endmodule
`default_nettype wire

// ===== test/vector_angle_tb.sv =====
// ----------------------------------------------------------------------------
// vector_angle_tb
// streams element pairs into the vector angle block and checks every result
// against a bit-accurate fixed-point predictor or a typed-in directed result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module vector_angle_tb;
  import va_pkg::*;

  typedef struct {
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic               last;
  } pair_t;

  typedef struct {
    logic signed [47:0] dot;
    logic [23:0]        na;
    logic [23:0]        nb;
    logic [14:0]        ang;
    logic               ang_ok;
  } angle_res_t;

  // directed row: pair plus optional typed-in result
  typedef struct {
    pair_t      p;
    bit         fixed;
    angle_res_t r;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  va_in_if  in_ch();
  va_out_if out_ch();

  vector_angle u_dut (.clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source));

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  angle_res_t expected_q[$];
  int  errors = 0;
  int  idle_cycles = 0;
  longint pred_dot, pred_sa, pred_sb;

  // saturating 48-bit add
  function automatic longint acc_add(longint acc, longint p);
    longint s;
    s = acc + p;
    if (s > 64'sh7FFF_FFFF_FFFF) s = 64'sh7FFF_FFFF_FFFF;
    if (s < -64'sh8000_0000_0000) s = -64'sh8000_0000_0000;
    return s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, bt;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= r + bt) begin
        v -= r + bt;
        r = (r >> 1) + bt;
      end else begin
        r >>= 1;
      end
      bt >>= 2;
    end
    return r;
  endfunction

  function automatic longint atan_step(int i);
    longint tbl [17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256,
                         128, 64, 32, 16, 8, 4, 2, 1};
    return tbl[i];
  endfunction

  // cosine by long division, sine by sqrt, then cordic vectoring
  function automatic longint unsigned calc_angle(longint dot, longint unsigned den);
    longint unsigned mag, r, q;
    longint c, s, x, y, z, xs, ys, a;
    mag = (dot < 0) ? longint'(-dot) : dot;
    z = 0;
    if (mag >= den) begin
      c = 64'sd1 << 30;
    end else begin
      r = mag;
      q = 0;
      for (int i = 0; i < 30; i++) begin
        r <<= 1;
        q <<= 1;
        if (r >= den) begin
          r -= den;
          q |= 1;
        end
      end
      c = q;
    end
    s = int_sqrt((64'd1 << 60) - longint'(c) * longint'(c));
    x = c;
    y = s;
    for (int i = 0; i < 17; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += atan_step(i);
      end else begin
        x -= ys; y += xs; z -= atan_step(i);
      end
    end
    a = (dot < 0) ? 205887 - z : z;
    a = (a + 4) >>> 3;
    if (a < 0) a = 0;
    if (a > 25736) a = 25736;
    return a;
  endfunction

  // accumulate one pair; returns 1 with a result on last
  function automatic bit predict_angle(pair_t p, output angle_res_t r);
    longint a, b;
    longint unsigned na, nb;
    a = p.a;
    b = p.b;
    pred_dot = acc_add(pred_dot, a * b);
    pred_sa  = acc_add(pred_sa, a * a);
    pred_sb  = acc_add(pred_sb, b * b);
    if (!p.last) return 1'b0;
    na = int_sqrt(pred_sa);
    nb = int_sqrt(pred_sb);
    r.dot = pred_dot[47:0];
    r.na  = na[23:0];
    r.nb  = nb[23:0];
    if (na == 0 || nb == 0) begin
      r.ang = '0;
      r.ang_ok = 1'b0;
    end else begin
      r.ang = 15'(calc_angle(pred_dot, na * nb));
      r.ang_ok = 1'b1;
    end
    pred_dot = 0; pred_sa = 0; pred_sb = 0;
    return 1'b1;
  endfunction

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: random stalls and checking
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result dot=%0d", $time, out_ch.dot_product);
        errors++;
      end else begin
        angle_res_t e;
        e = expected_q.pop_front();
        if (out_ch.dot_product !== e.dot) begin
          $display("%0t: dot_product exp %0d got %0d", $time, e.dot, out_ch.dot_product);
          errors++;
        end
        if (out_ch.norm_a !== e.na) begin
          $display("%0t: norm_a exp %0d got %0d", $time, e.na, out_ch.norm_a);
          errors++;
        end
        if (out_ch.norm_b !== e.nb) begin
          $display("%0t: norm_b exp %0d got %0d", $time, e.nb, out_ch.norm_b);
          errors++;
        end
        if (out_ch.angle !== e.ang) begin
          $display("%0t: angle exp %0d got %0d", $time, e.ang, out_ch.angle);
          errors++;
        end
        if (out_ch.angle_valid !== e.ang_ok) begin
          $display("%0t: angle_valid exp %0b got %0b", $time, e.ang_ok, out_ch.angle_valid);
          errors++;
        end
      end
    end
  end

  // one pair transfer with optional preceding gap
  task automatic send_pair(pair_t p, bit fixed, angle_res_t fr, int gap);
    angle_res_t r;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.elem_a <= p.a;
    in_ch.elem_b <= p.b;
    in_ch.last   <= p.last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (predict_angle(p, r)) expected_q.push_back(fixed ? fr : r);
  endtask

  function automatic logic signed [15:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return -16'sh8000;
      2: return 16'($signed($urandom_range(0, 63)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    row_t rows[$];
    row_t rw;
    pair_t p;
    int len, gap;
    in_ch.valid = 1'b0;
    in_ch.elem_a = '0;
    in_ch.elem_b = '0;
    in_ch.last = 1'b0;
    pred_dot = 0; pred_sa = 0; pred_sb = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows
    rw = '{p: '{16'sd0, 16'sd0, 1'b1}, fixed: 1'b1, r: '{48'sd0, 24'd0, 24'd0, 15'd0, 1'b0}};
    rows.push_back(rw);
    rw = '{p: '{16'sd256, 16'sd0, 1'b1}, fixed: 1'b1,
           r: '{48'sd0, 24'd256, 24'd0, 15'd0, 1'b0}};
    rows.push_back(rw);
    rw = '{p: '{16'sd256, 16'sd256, 1'b1}, fixed: 1'b1,
           r: '{48'sd65536, 24'd256, 24'd256, 15'd0, 1'b1}};
    rows.push_back(rw);
    rw = '{p: '{16'sd256, -16'sd256, 1'b1}, fixed: 1'b1,
           r: '{-48'sd65536, 24'd256, 24'd256, 15'd25736, 1'b1}};
    rows.push_back(rw);
    rw = '{p: '{-16'sh8000, -16'sh8000, 1'b1}, fixed: 1'b1,
           r: '{48'sd1073741824, 24'd32768, 24'd32768, 15'd0, 1'b1}};
    rows.push_back(rw);
    rw.fixed = 1'b0;
    rw.p = '{16'sh7FFF, -16'sh8000, 1'b1}; rows.push_back(rw);
    rw.p = '{16'sh7FFF, 16'sh7FFF, 1'b0}; rows.push_back(rw);
    rw.p = '{-16'sh8000, 16'sh7FFF, 1'b1}; rows.push_back(rw);
    rw.p = '{16'sd256, 16'sd0, 1'b0}; rows.push_back(rw);
    rw.p = '{16'sd0, 16'sd256, 1'b1}; rows.push_back(rw);
    rw.p = '{16'sd3, 16'sd5, 1'b0}; rows.push_back(rw);
    rw.p = '{16'sd7, -16'sd2, 1'b1}; rows.push_back(rw);
    rw.p = '{16'sd1, 16'sd1, 1'b0}; rows.push_back(rw);
    rw.p = '{16'sd1, 16'sd0, 1'b1}; rows.push_back(rw);
    rw.p = '{-16'sd1, 16'sd1, 1'b1}; rows.push_back(rw);
    foreach (rows[i]) send_pair(rows[i].p, rows[i].fixed, rows[i].r, $urandom_range(0, 2));

    // pause until drained
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);

    // random vectors, mostly short
    for (int n = 0; n < 500; n += len) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      for (int k = 0; k < len; k++) begin
        p.a = rand_elem();
        p.b = rand_elem();
        p.last = (k == len - 1);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        if ((n / 100) % 2 == 1) gap = 0;
        send_pair(p, 1'b0, '{default: '0}, gap);
      end
    end
    in_ch.valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
